/* design/sfod_pkg.sv */
// shared constants, types and codes of the spectral flux onset detector
`default_nettype none

package sfod_pkg;

   // frame and history sizes (HISTORY_DEPTH must be a power of two)
   localparam int MAX_BINS      = 1024;
   localparam int HISTORY_DEPTH = 32;

   // field widths
   localparam int MAG_W      = 16;
   localparam int ELAPSED_W  = 20;
   localparam int FLUX_W     = 26;
   localparam int THRESH_W   = 29;
   localparam int GAIN_W     = 11;
   localparam int SCALE_W    = 12;
   localparam int COOLDOWN_W = 21;

   // derived widths
   localparam int BIN_IDX_W    = $clog2(MAX_BINS);
   localparam int BIN_CNT_W    = $clog2(MAX_BINS + 1);
   localparam int SLOT_W       = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int TOTAL_W      = FLUX_W + SLOT_W;
   localparam int TPROD_W      = TOTAL_W + GAIN_W;
   localparam int DPROD_W      = THRESH_W + SCALE_W;
   localparam int Q8_FRAC      = 8;
   localparam int THRESH_SHIFT = $clog2(HISTORY_DEPTH) + Q8_FRAC;

   // saturation limits
   localparam logic [FLUX_W-1:0]   FLUX_MAX   = {FLUX_W{1'b1}};
   localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};

   // register reset values
   localparam logic [GAIN_W-1:0]     GAIN_RESET     = GAIN_W'(384);
   localparam logic [SCALE_W-1:0]    SCALE_RESET    = SCALE_W'(512);
   localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = COOLDOWN_W'(500000);

   // configuration bus
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   typedef enum logic [1:0] {
      CSR_THRESHOLD_GAIN   = 2'd0,
      CSR_DROP_SCALE       = 2'd1,
      CSR_DROP_COOLDOWN_US = 2'd2
   } sfod_csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]     threshold_gain;
      logic [SCALE_W-1:0]    drop_scale;
      logic [COOLDOWN_W-1:0] drop_cooldown_us;
   } sfod_cfg_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIN,
      ST_FRAME,
      ST_THRESH,
      ST_SCALE,
      ST_DECIDE
   } sfod_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic bin_update;
      logic frame_end;
      logic thresh_mul;
      logic scale_mul;
      logic decide;
   } sfod_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic last_bin;
      logic frame_match;
      logic out_free;
   } sfod_status_type;

endpackage

`default_nettype wire

/* design/sfod_if.sv */
// valid/ready channel interfaces for bins in and detection results out
`default_nettype none

interface sfod_req_if import sfod_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAG_W-1:0]     magnitude;
   logic                 last_bin;
   logic [ELAPSED_W-1:0] elapsed_us;

   modport source (output valid, output magnitude, output last_bin, output elapsed_us,
                   input ready);
   modport sink   (input valid, input magnitude, input last_bin, input elapsed_us,
                   output ready);
endinterface

interface sfod_rsp_if import sfod_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FLUX_W-1:0]   flux;
   logic [THRESH_W-1:0] threshold;
   logic                onset;
   logic                drop;

   modport source (output valid, output flux, output threshold, output onset, output drop,
                   input ready);
   modport sink   (input valid, input flux, input threshold, input onset, input drop,
                   output ready);
endinterface

`default_nettype wire

/* design/spectral_flux_onset_detector.sv */
// spectral flux onset detector top level
//
// Bins enter on the req channel (valid/ready), one magnitude per transaction,
// with last_bin on the final bin of a frame and elapsed_us on that bin.
// For each bin, the accept cycle reads the stored previous-frame
// bin from the single-port bin memory, the next cycle adds the positive rise
// and writes the new magnitude back; req is ready again after a non-final bin.
// On a final bin the frame count is checked; a frame whose bin count differs
// from the stored one ends in the frame step with no result. A matching frame
// runs the ring update, the gain multiply and the drop-scale multiply, and
// its result is loaded into the rsp output register in the decision step;
// the next bin is taken only after that step.
// The rsp register holds a result until taken. While it is full and unread,
// a new result waits in the decision step and req stays not ready.
// Thresholds, drop scale and cooldown come from the APB registers at byte
// addresses 0, 4 and 8; write them only while the block is idle.
// Synchronous reset clears the history ring, counts and cooldown and loads
// the register defaults; the bin memory is not cleared.
`default_nettype none

module spectral_flux_onset_detector import sfod_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   sfod_req_if.sink                req,
   sfod_rsp_if.source              rsp,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   sfod_cfg_type    cfg;
   sfod_cmd_type    cmd;
   sfod_status_type status;

   sfod_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sfod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .status    (status),
      .req_ready (req.ready),
      .cmd       (cmd)
   );

   sfod_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .req_magnitude  (req.magnitude),
      .req_last_bin   (req.last_bin),
      .req_elapsed_us (req.elapsed_us),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_flux       (rsp.flux),
      .rsp_threshold  (rsp.threshold),
      .rsp_onset      (rsp.onset),
      .rsp_drop       (rsp.drop),
      .status         (status)
   );

endmodule

`default_nettype wire

/* design/sfod_ram.sv */
// generic single-port ram with registered read
`default_nettype none

module sfod_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first storage
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* design/sfod_csr.sv */
// apb-style configuration registers
`default_nettype none

module sfod_csr import sfod_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output sfod_cfg_type            cfg
);

   sfod_cfg_type       cfg_ff, cfg_in;
   sfod_csr_index_type index;
   logic               write_en;

   assign pready   = 1'b1;
   assign index    = sfod_csr_index_type'(paddr[PADDR_W-1:2]);
   assign write_en = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            CSR_THRESHOLD_GAIN:   cfg_in.threshold_gain   = pwdata[GAIN_W-1:0];
            CSR_DROP_SCALE:       cfg_in.drop_scale       = pwdata[SCALE_W-1:0];
            CSR_DROP_COOLDOWN_US: cfg_in.drop_cooldown_us = pwdata[COOLDOWN_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_gain   <= GAIN_RESET;
         cfg_ff.drop_scale       <= SCALE_RESET;
         cfg_ff.drop_cooldown_us <= COOLDOWN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         CSR_THRESHOLD_GAIN:   prdata = PDATA_W'(cfg_ff.threshold_gain);
         CSR_DROP_SCALE:       prdata = PDATA_W'(cfg_ff.drop_scale);
         CSR_DROP_COOLDOWN_US: prdata = PDATA_W'(cfg_ff.drop_cooldown_us);
         default:              prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* design/sfod_datapath.sv */
// bin accumulation, history ring, threshold and decision datapath
`default_nettype none

module sfod_datapath import sfod_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sfod_cmd_type         cmd,
   input  wire sfod_cfg_type         cfg,
   input  wire logic [MAG_W-1:0]     req_magnitude,
   input  wire logic                 req_last_bin,
   input  wire logic [ELAPSED_W-1:0] req_elapsed_us,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic      [FLUX_W-1:0]    rsp_flux,
   output logic      [THRESH_W-1:0]  rsp_threshold,
   output logic                      rsp_onset,
   output logic                      rsp_drop,
   output sfod_status_type           status
);

   // captured transaction
   logic [MAG_W-1:0]     mag_ff;
   logic                 last_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;

   // frame and history state
   logic [BIN_CNT_W-1:0]  bins_seen_ff, bins_seen_in;
   logic [FLUX_W-1:0]     flux_sum_ff, flux_sum_in;
   logic [BIN_CNT_W-1:0]  prior_bins_ff, prior_bins_in;
   logic [FLUX_W-1:0]     hist_ff [HISTORY_DEPTH];
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [COOLDOWN_W-1:0] cooldown_ff, cooldown_in;

   // arithmetic pipeline
   logic [FLUX_W-1:0]   flux_ff;
   logic [TPROD_W-1:0]  tprod_ff;
   logic [THRESH_W-1:0] thr_ff;
   logic [DPROD_W-1:0]  dprod_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FLUX_W-1:0]   rsp_flux_ff;
   logic [THRESH_W-1:0] rsp_thr_ff;
   logic                rsp_onset_ff;
   logic                rsp_drop_ff;

   // previous frame storage
   logic [MAG_W-1:0] old_mag;
   logic             bin_room;
   logic             ram_we;

   assign bin_room = bins_seen_ff < BIN_CNT_W'(MAX_BINS);
   assign ram_we   = cmd.bin_update && bin_room;

   sfod_ram #(
      .WIDTH (MAG_W),
      .DEPTH (MAX_BINS)
   ) u_prev_bins (
      .clock (clock),
      .addr  (bins_seen_ff[BIN_IDX_W-1:0]),
      .we    (ram_we),
      .wdata (mag_ff),
      .rdata (old_mag)
   );

   // positive rise accumulation with saturation
   logic [FLUX_W:0]   rise_sum;
   logic [FLUX_W-1:0] rise_sat;
   always_comb begin
      rise_sum = (FLUX_W + 1)'(flux_sum_ff) + (FLUX_W + 1)'(mag_ff - old_mag);
      rise_sat = (rise_sum > (FLUX_W + 1)'(FLUX_MAX)) ? FLUX_MAX : rise_sum[FLUX_W-1:0];
   end

   // frame end bookkeeping
   logic                  frame_match;
   logic [COOLDOWN_W-1:0] elapsed_ext;
   logic [COOLDOWN_W-1:0] cooldown_dec;
   assign frame_match  = bins_seen_ff == prior_bins_ff;
   assign elapsed_ext  = COOLDOWN_W'(elapsed_ff);
   assign cooldown_dec = (cooldown_ff > elapsed_ext) ? cooldown_ff - elapsed_ext : '0;

   // threshold from the averaged product
   logic [TPROD_W-1:0]  tprod_shift;
   logic [THRESH_W-1:0] thr_c;
   always_comb begin
      tprod_shift = tprod_ff >> THRESH_SHIFT;
      thr_c = (tprod_shift > TPROD_W'(THRESH_MAX)) ? THRESH_MAX
                                                   : tprod_shift[THRESH_W-1:0];
   end

   // onset and drop decisions
   logic onset_c, drop_c;
   always_comb begin
      onset_c = (thr_ff != '0) && ((DPROD_W'(flux_ff)) > (DPROD_W'(thr_ff)));
      drop_c  = onset_c && ((DPROD_W'(flux_ff) << Q8_FRAC) > dprod_ff)
                && (cooldown_ff == '0);
   end

   // next state of frame and history
   always_comb begin
      bins_seen_in  = bins_seen_ff;
      flux_sum_in   = flux_sum_ff;
      prior_bins_in = prior_bins_ff;
      total_in      = total_ff;
      slot_in       = slot_ff;
      cooldown_in   = cooldown_ff;
      if (cmd.bin_update && bin_room) begin
         bins_seen_in = bins_seen_ff + BIN_CNT_W'(1);
         if (mag_ff > old_mag) begin
            flux_sum_in = rise_sat;
         end
      end
      if (cmd.frame_end) begin
         bins_seen_in = '0;
         flux_sum_in  = '0;
         if (!frame_match) begin
            prior_bins_in = bins_seen_ff;
         end else begin
            total_in    = total_ff - TOTAL_W'(hist_ff[slot_ff]) + TOTAL_W'(flux_sum_ff);
            slot_in     = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                  : slot_ff + SLOT_W'(1);
            cooldown_in = cooldown_dec;
         end
      end
      if (cmd.decide && drop_c) begin
         cooldown_in = cfg.drop_cooldown_us;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_seen_ff  <= '0;
         flux_sum_ff   <= '0;
         prior_bins_ff <= '0;
         total_ff      <= '0;
         slot_ff       <= '0;
         cooldown_ff   <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         bins_seen_ff  <= bins_seen_in;
         flux_sum_ff   <= flux_sum_in;
         prior_bins_ff <= prior_bins_in;
         total_ff      <= total_in;
         slot_ff       <= slot_in;
         cooldown_ff   <= cooldown_in;
         if (cmd.frame_end && frame_match) begin
            hist_ff[slot_ff] <= flux_sum_ff;
         end
      end
   end

   // payload and arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mag_ff     <= req_magnitude;
         last_ff    <= req_last_bin;
         elapsed_ff <= req_elapsed_us;
      end
      if (cmd.frame_end) begin
         flux_ff <= flux_sum_ff;
      end
      if (cmd.thresh_mul) begin
         tprod_ff <= total_ff * TPROD_W'(cfg.threshold_gain);
      end
      if (cmd.scale_mul) begin
         thr_ff   <= thr_c;
         dprod_ff <= DPROD_W'(thr_c) * DPROD_W'(cfg.drop_scale);
      end
      if (cmd.decide) begin
         rsp_flux_ff  <= flux_ff;
         rsp_thr_ff   <= thr_ff;
         rsp_onset_ff <= onset_c;
         rsp_drop_ff  <= drop_c;
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_flux      = rsp_flux_ff;
   assign rsp_threshold = rsp_thr_ff;
   assign rsp_onset     = rsp_onset_ff;
   assign rsp_drop      = rsp_drop_ff;

   assign status.last_bin    = last_ff;
   assign status.frame_match = frame_match;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

/* design/sfod_ctrl.sv */
// sequencing state machine for bins and frame decisions
`default_nettype none

module sfod_ctrl import sfod_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire sfod_status_type status,
   output logic                 req_ready,
   output sfod_cmd_type         cmd
);

   sfod_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            state_in = status.last_bin ? ST_FRAME : ST_IDLE;
         end
         ST_FRAME: begin
            state_in = status.frame_match ? ST_THRESH : ST_IDLE;
         end
         ST_THRESH: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_BIN: begin
            cmd.bin_update = 1'b1;
         end
         ST_FRAME: begin
            cmd.frame_end = 1'b1;
         end
         ST_THRESH: begin
            cmd.thresh_mul = 1'b1;
         end
         ST_SCALE: begin
            cmd.scale_mul = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* dv/sfod_checker.sv */
// scoreboard for the spectral flux onset detector: predicts detection results and checks rsp
module sfod_checker import sfod_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   sfod_req_if                     req,
   sfod_rsp_if                     rsp,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic               pready,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output int unsigned             due_count,
   output int unsigned             fault_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic [FLUX_W-1:0]   flux;
      logic [THRESH_W-1:0] threshold;
      logic                onset;
      logic                drop;
   } detection_type;

   // expected detections, oldest first
   detection_type detections_due [$];

   // register copies
   logic [GAIN_W-1:0]     gain_reg;
   logic [SCALE_W-1:0]    scale_reg;
   logic [COOLDOWN_W-1:0] cooldown_reg;

   // spectrum and history state
   bit   [MAG_W-1:0]      last_mag [MAX_BINS];
   logic [FLUX_W-1:0]     flux_ring [HISTORY_DEPTH];
   logic [TOTAL_W-1:0]    ring_total;
   logic [SLOT_W-1:0]     ring_slot;
   logic [COOLDOWN_W-1:0] cooldown_left;
   logic [FLUX_W-1:0]     flux_in_frame;
   logic [BIN_CNT_W-1:0]  bins_in_frame;
   logic [BIN_CNT_W-1:0]  prior_bins;
   int unsigned           faults;

   // fold one accepted bin into the frame, closing the frame on its last bin
   task automatic fold_bin(input logic [MAG_W-1:0] mag, input logic last,
                           input logic [ELAPSED_W-1:0] elapsed);
      logic [FLUX_W:0]      rise_sum;
      logic [BIN_IDX_W-1:0] pos;
      logic [BIN_CNT_W-1:0] closed_bins;
      logic [FLUX_W-1:0]    closed_flux;
      logic [63:0]          gained;
      logic [THRESH_W-1:0]  thr;
      detection_type        d;

      // bins past the frame capacity are dropped
      if (int'(bins_in_frame) < MAX_BINS) begin
         pos = bins_in_frame[BIN_IDX_W-1:0];
         if (mag > last_mag[pos]) begin
            rise_sum = {1'b0, flux_in_frame} + (FLUX_W+1)'(mag - last_mag[pos]);
            flux_in_frame = rise_sum[FLUX_W] ? FLUX_MAX : rise_sum[FLUX_W-1:0];
         end
         last_mag[pos] = mag;
         bins_in_frame = bins_in_frame + 1'b1;
      end
      if (!last) return;

      closed_bins   = bins_in_frame;
      closed_flux   = flux_in_frame;
      bins_in_frame = '0;
      flux_in_frame = '0;

      // a frame of a new size is only stored
      if (closed_bins != prior_bins) begin
         prior_bins = closed_bins;
         return;
      end

      // history ring and running sum
      ring_total = ring_total - TOTAL_W'(flux_ring[ring_slot]) + TOTAL_W'(closed_flux);
      flux_ring[ring_slot] = closed_flux;
      ring_slot = (int'(ring_slot) == HISTORY_DEPTH - 1) ? '0 : ring_slot + 1'b1;

      // threshold: ring average times gain, truncated and saturated
      gained = (64'(ring_total) * 64'(gain_reg)) >> THRESH_SHIFT;
      thr = (gained > 64'(THRESH_MAX)) ? THRESH_MAX : gained[THRESH_W-1:0];

      // cooldown runs down by the frame step, stopping at zero
      if (cooldown_left != '0)
         cooldown_left = (cooldown_left > COOLDOWN_W'(elapsed)) ?
                         cooldown_left - COOLDOWN_W'(elapsed) : '0;

      d.flux      = closed_flux;
      d.threshold = thr;
      d.onset     = 1'b0;
      d.drop      = 1'b0;
      if (thr != '0 && closed_flux > thr) begin
         d.onset = 1'b1;
         if ((64'(closed_flux) << 8) > 64'(thr) * 64'(scale_reg) && cooldown_left == '0) begin
            d.drop = 1'b1;
            cooldown_left = cooldown_reg;
         end
      end
      detections_due.push_back(d);
   endtask

   // watch config, bins and results at every edge
   always @(posedge clock) begin
      detection_type seen;
      detection_type want;
      if (reset) begin
         gain_reg      = GAIN_RESET;
         scale_reg     = SCALE_RESET;
         cooldown_reg  = COOLDOWN_RESET;
         for (int i = 0; i < HISTORY_DEPTH; i++) flux_ring[i] = '0;
         ring_total    = '0;
         ring_slot     = '0;
         cooldown_left = '0;
         flux_in_frame = '0;
         bins_in_frame = '0;
         prior_bins    = '0;
         faults        = 0;
         detections_due.delete();
      end else begin
         // register writes, unknown indexes ignored
         if (psel && penable && pwrite && pready) begin
            case (paddr[PADDR_W-1:2])
               CSR_THRESHOLD_GAIN:   gain_reg     = pwdata[GAIN_W-1:0];
               CSR_DROP_SCALE:       scale_reg    = pwdata[SCALE_W-1:0];
               CSR_DROP_COOLDOWN_US: cooldown_reg = pwdata[COOLDOWN_W-1:0];
               default: ;
            endcase
         end

         if (req.valid && req.ready)
            fold_bin(req.magnitude, req.last_bin, req.elapsed_us);

         // compare each result transaction with the oldest expectation
         if (rsp.valid && rsp.ready) begin
            seen.flux      = rsp.flux;
            seen.threshold = rsp.threshold;
            seen.onset     = rsp.onset;
            seen.drop      = rsp.drop;
            if (detections_due.size() == 0) begin
               if (faults < REPORT_LIMIT)
                  $display("%0t detection with none expected: %s %0d %s %0d %s %0b %s %0b",
                           $time, "flux", seen.flux, "threshold", seen.threshold,
                           "onset", seen.onset, "drop", seen.drop);
               faults++;
            end else begin
               want = detections_due.pop_front();
               if (seen !== want) begin
                  if (faults < REPORT_LIMIT) begin
                     $display("%0t detection mismatch", $time);
                     $display("   expected flux %0d threshold %0d onset %0b drop %0b",
                              want.flux, want.threshold, want.onset, want.drop);
                     $display("   actual   flux %0d threshold %0d onset %0b drop %0b",
                              seen.flux, seen.threshold, seen.onset, seen.drop);
                  end
                  faults++;
               end
            end
         end
      end
      due_count   <= detections_due.size();
      fault_count <= faults;
   end

endmodule

/* dv/spectral_flux_onset_detector_tb.sv */
// testbench top for the spectral flux onset detector: stimulus, handshake idling and verdict
module spectral_flux_onset_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sfod_pkg::*;

   localparam int          CYCLE_LIMIT   = 5000000;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          RANDOM_BINS   = 1000;
   localparam int          PHASES        = 8;
   localparam int          OVERLONG_BINS = MAX_BINS + 6;
   localparam logic [1:0]  CSR_UNMAPPED  = 2'd3;

   typedef enum logic [2:0] {
      SHAPE_SILENT,
      SHAPE_FULL,
      SHAPE_NOISE,
      SHAPE_QUIET,
      SHAPE_HOLD,
      SHAPE_BURST
   } frame_shape_type;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;
   int unsigned        due_count;
   int unsigned        fault_count;
   int unsigned        cycle_count = 0;

   // stimulus memory: magnitudes last sent at each bin position
   bit [MAG_W-1:0]     sent_mag [MAX_BINS];
   int unsigned        bin_pos;
   int unsigned        bins_sent;
   bit                 req_calm;

   sfod_req_if req_ch ();
   sfod_rsp_if rsp_ch ();

   spectral_flux_onset_detector dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sfod_checker detect_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .due_count   (due_count),
      .fault_count (fault_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // idle length: mostly none or short, a few long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(20, 60);
   endfunction

   // result side stalls, with calm stretches
   initial begin
      int stall_left;
      int calm_left;
      bit calm;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(100, 400);
         end else begin
            calm_left--;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm) stall_left = idle_span();
         end
      end
   end

   // one bin transaction, with an optional gap before it
   task automatic send_bin(input logic [MAG_W-1:0] mag, input logic last,
                           input logic [ELAPSED_W-1:0] elapsed);
      int gap;
      gap = req_calm ? 0 : idle_span();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.magnitude  <= mag;
      req_ch.last_bin   <= last;
      req_ch.elapsed_us <= elapsed;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (bin_pos < MAX_BINS) sent_mag[bin_pos] = mag;
      bin_pos = last ? 0 : bin_pos + 1;
      bins_sent++;
      if ($urandom_range(0, 63) == 0) req_calm = ~req_calm;
   endtask

   // a whole frame of the given shape
   task automatic send_frame(input int nbins, input frame_shape_type shape,
                             input logic [ELAPSED_W-1:0] elapsed);
      logic [MAG_W-1:0] mag;
      for (int i = 0; i < nbins; i++) begin
         case (shape)
            SHAPE_SILENT: mag = '0;
            SHAPE_FULL:   mag = '1;
            SHAPE_NOISE:  mag = MAG_W'($urandom_range(0, 65535));
            SHAPE_QUIET:  mag = MAG_W'($urandom_range(0, 511));
            SHAPE_HOLD:   mag = (i < MAX_BINS) ? sent_mag[i] : MAG_W'($urandom);
            default:      mag = ($urandom_range(0, 3) == 0) ?
                                MAG_W'($urandom_range(40000, 65535)) :
                                MAG_W'($urandom_range(0, 255));
         endcase
         send_bin(mag, i == nbins - 1, (i == nbins - 1) ? elapsed : ELAPSED_W'($urandom));
      end
   endtask

   // apb write: setup then access
   task automatic csr_write(input logic [1:0] index, input logic [PDATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // drain outstanding results, then let the block go idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (due_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // main stimulus
   initial begin
      int                     phase_start;
      int                     base_bins;
      int                     nbins;
      int                     r;
      frame_shape_type        shape;
      logic [ELAPSED_W-1:0]   elapsed;
      logic [PDATA_W-1:0]     gain_v;
      logic [PDATA_W-1:0]     scale_v;
      logic [PDATA_W-1:0]     cool_v;

      bin_pos   = 0;
      bins_sent = 0;
      req_calm  = 1'b0;
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.magnitude  <= '0;
      req_ch.last_bin   <= 1'b0;
      req_ch.elapsed_us <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-bin frames under reset settings
      send_bin(16'd0, 1'b1, 20'd0);          // first frame: no previous count, stored only
      send_bin(16'd0, 1'b1, 20'd0);          // empty history: zero threshold, no onset
      send_bin(16'hFFFF, 1'b1, 20'd1000000); // full rise: onset and drop, cooldown loads
      send_bin(16'd0, 1'b1, 20'd1000);       // falling bin adds no flux
      send_bin(16'hFFFF, 1'b1, 20'd100);     // onset while cooldown still running
      send_bin(16'd0, 1'b1, 20'd0);
      send_bin(16'hFFFF, 1'b1, 20'd1000000); // step exceeds the remaining cooldown

      // two-bin frames: new count, then rises and falls per bin
      send_bin(16'hFFFF, 1'b0, 20'hFFFFF);
      send_bin(16'd0, 1'b1, 20'd0);
      send_bin(16'd0, 1'b0, 20'd0);
      send_bin(16'hFFFF, 1'b1, 20'd5000);
      send_bin(16'h8000, 1'b0, 20'd0);
      send_bin(16'h7FFF, 1'b1, 20'd999999);
      send_bin(16'h7FFF, 1'b0, 20'h55555);
      send_bin(16'h8000, 1'b1, 20'd524288);
      send_bin(16'h8000, 1'b0, 20'h2AAAA);
      send_bin(16'h8000, 1'b1, 20'd1);

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin gain_v = 256;   scale_v = 256;   cool_v = 0;       end
            1: begin gain_v = 1280;  scale_v = 2048;  cool_v = 2000000; end
            2: begin gain_v = 384;   scale_v = 512;   cool_v = 20000;   end
            3: begin gain_v = '1;    scale_v = '1;    cool_v = '1;      end
            4: begin gain_v = 0;     scale_v = 0;     cool_v = 0;       end
            5: begin gain_v = 512;   scale_v = 300;   cool_v = 100000;  end
            default: begin
               gain_v  = $urandom_range(256, 1280);
               scale_v = $urandom_range(256, 2048);
               cool_v  = $urandom_range(0, 2000000);
            end
         endcase
         csr_write(CSR_THRESHOLD_GAIN, gain_v);
         csr_write(CSR_DROP_SCALE, scale_v);
         csr_write(CSR_DROP_COOLDOWN_US, cool_v);
         // write beyond the register list must change nothing
         if (p == 3) csr_write(CSR_UNMAPPED, '1);

         req_calm    = ($urandom_range(0, 3) == 0);
         base_bins   = $urandom_range(2, 12);
         phase_start = bins_sent;
         while (bins_sent - phase_start < RANDOM_BINS / PHASES) begin
            // mostly frames of the running size, sometimes a new size or a stray one
            r = $urandom_range(0, 99);
            if (r < 5) begin
               r = $urandom_range(0, 9);
               base_bins = (r == 0) ? 1 : (r < 8) ? $urandom_range(2, 12) :
                           $urandom_range(16, 64);
               nbins = base_bins;
            end else if (r < 15) begin
               nbins = $urandom_range(1, 20);
            end else begin
               nbins = base_bins;
            end

            r = $urandom_range(0, 99);
            shape = (r < 30) ? SHAPE_HOLD  : (r < 50) ? SHAPE_QUIET :
                    (r < 75) ? SHAPE_NOISE : (r < 90) ? SHAPE_BURST :
                    (r < 95) ? SHAPE_SILENT : SHAPE_FULL;

            r = $urandom_range(0, 9);
            elapsed = (r == 0) ? ELAPSED_W'(0) : (r == 1) ? ELAPSED_W'(1000000) :
                      (r < 7) ? ELAPSED_W'($urandom_range(0, 50000)) :
                      ELAPSED_W'($urandom_range(0, 1000000));

            send_frame(nbins, shape, elapsed);
         end

         // overlong frames: count saturates at capacity, then an exact full frame
         if (p == 0) begin
            send_frame(OVERLONG_BINS, SHAPE_NOISE, ELAPSED_W'($urandom_range(0, 1000000)));
            send_frame(OVERLONG_BINS, SHAPE_BURST, ELAPSED_W'($urandom_range(0, 1000000)));
            send_frame(MAX_BINS, SHAPE_FULL, ELAPSED_W'($urandom_range(0, 1000000)));
         end
      end

      settle();
      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/sfod_pkg.sv
design/sfod_if.sv
design/sfod_ram.sv
design/sfod_csr.sv
design/sfod_datapath.sv
design/sfod_ctrl.sv
design/spectral_flux_onset_detector.sv
dv/sfod_checker.sv
dv/spectral_flux_onset_detector_tb.sv
